>>> rtl/vt2a_pkg.sv
// ----------------------------------------------------------------------------
// VT52 to ANSI translator package
// Shared character codes, the escape phase type and the decimal digit helpers.
// ----------------------------------------------------------------------------
package vt2a_pkg;

    localparam int unsigned MAX_SEQ   = 8;
    localparam int unsigned SEQ_IDX_W = $clog2(MAX_SEQ);
    localparam int unsigned SEQ_LEN_W = $clog2(MAX_SEQ + 1);

    localparam logic [6:0] CH_ESC      = 7'h1B;
    localparam logic [6:0] CH_LBRACKET = 7'h5B;
    localparam logic [6:0] CH_SLASH    = 7'h2F;
    localparam logic [6:0] CH_SEMI     = 7'h3B;
    localparam logic [6:0] CH_ZERO     = 7'h30;
    localparam logic [6:0] CH_A        = 7'h41;
    localparam logic [6:0] CH_B        = 7'h42;
    localparam logic [6:0] CH_C        = 7'h43;
    localparam logic [6:0] CH_D        = 7'h44;
    localparam logic [6:0] CH_H        = 7'h48;
    localparam logic [6:0] CH_I        = 7'h49;
    localparam logic [6:0] CH_J        = 7'h4A;
    localparam logic [6:0] CH_K        = 7'h4B;
    localparam logic [6:0] CH_M        = 7'h4D;
    localparam logic [6:0] CH_Y        = 7'h59;
    localparam logic [6:0] CH_Z        = 7'h5A;
    localparam logic [6:0] CH_LOW_LO   = 7'h60;
    localparam logic [6:0] CH_LOW_HI   = 7'h7E;
    localparam logic [6:0] COORD_BIAS  = 7'h1F;

    // Escape phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_ROW  = 4'b0100,
        PH_COL  = 4'b1000
    } phase_t;

    // Coordinate from an address byte, clamped at zero.
    function automatic logic [6:0] coord_of(input logic [6:0] b);
        coord_of = (b >= COORD_BIAS) ? (b - COORD_BIAS) : 7'd0;
    endfunction

    // Tens digit of a value below 128: multiply by 205/2048, exact below 1029.
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod    = 15'(v) * 15'd205;
        tens_of = prod[14:11];
    endfunction

    function automatic logic [7:0] tens_char(input logic [6:0] v);
        tens_char = {1'b0, CH_ZERO + 7'(tens_of(v))};
    endfunction

    function automatic logic [7:0] ones_char(input logic [6:0] v);
        logic [6:0] ten_mult;
        ten_mult  = 7'(tens_of(v)) * 7'd10;
        ones_char = {1'b0, CH_ZERO + (v - ten_mult)};
    endfunction

endpackage

>>> rtl/vt52_to_ansi_translator_core.sv
// ----------------------------------------------------------------------------
// VT52 to ANSI translator core
// Rewrites a host byte stream of VT52 escapes into ANSI escapes, one byte out
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// An accepted item is one host byte, of which only the low 7 bits count. Each
// item causes zero to eight result items, delivered in order on the output
// channel one per cycle while out_stall is low, with last set on the final
// one. Printable bytes from 0x60 to 0x7E leave with bit 7 set and other plain
// bytes pass unchanged. ESC A, B, C, D, H, J and K become ESC [ letter, ESC I
// becomes ESC [ M, and ESC Y row col becomes ESC [ rr ; cc H with two decimal
// digits each, where a coordinate is the byte minus 31, clamped at zero. ESC Z
// produces the identify reply ESC / Z with to_host set; every other escape
// letter is silently dropped. A plain byte causes one result, a short escape
// three and a cursor address eight; the output port carries one byte per cycle
// while out_stall is low. A plain byte stream runs at one item per cycle while
// the output is not stalled. An accepted item passes the input register and
// then the expansion buffer before its first result is offered.
module vt52_to_ansi_translator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] out_byte,
    output logic       to_host,
    output logic       last,
    output logic       out_valid,
    input  logic       out_stall
);
    import vt2a_pkg::*;

    // Input register.
    logic       in_valid_reg, in_valid_next;
    logic [6:0] in_char_reg;

    // Escape state.
    phase_t     phase_reg, phase_next;
    logic [6:0] row_reg, row_next;

    // Expansion buffer: the bytes of the current item and a read pointer.
    logic [7:0]           seq_reg [MAX_SEQ];
    logic                 host_reg;
    logic [SEQ_LEN_W-1:0] len_reg, len_next;
    logic [SEQ_IDX_W-1:0] idx_reg, idx_next;

    // Decoded expansion of the byte in the input register.
    logic [7:0]           dec_seq [MAX_SEQ];
    logic                 dec_host;
    logic [SEQ_LEN_W-1:0] dec_len;
    logic [6:0]           col;

    logic busy, taking, finishing, buf_free, process, in_take;

    // The buffer is busy while it holds bytes not yet delivered. It can take
    // a new expansion when empty or when its final byte leaves this cycle.
    assign busy      = (len_reg != '0);
    assign taking    = busy && !out_stall;
    assign finishing = taking && last;
    assign buf_free  = !busy || finishing;
    assign process   = in_valid_reg && buf_free;

    // The input register frees up whenever its byte moves on.
    assign in_stall  = in_valid_reg && !buf_free;
    assign in_take   = in_valid && !in_stall;

    assign out_valid = busy;
    assign out_byte  = seq_reg[idx_reg];
    assign to_host   = host_reg;
    assign last      = ({1'b0, idx_reg} == (len_reg - SEQ_LEN_W'(1)));

    assign col = coord_of(in_char_reg);

    // Escape decoder: state update and the bytes to send.
    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        dec_host   = 1'b0;
        dec_len    = '0;
        for (int i = 0; i < MAX_SEQ; i++)
        begin
            dec_seq[i] = 8'h00;
        end
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_char_reg == CH_ESC)
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    dec_seq[0] = {(in_char_reg >= CH_LOW_LO) && (in_char_reg <= CH_LOW_HI),
                                  in_char_reg};
                    dec_len    = SEQ_LEN_W'(1);
                end
            end
            PH_ESC:
            begin
                phase_next = PH_IDLE;
                case (in_char_reg) inside
                    CH_A, CH_B, CH_C, CH_D, CH_H, CH_J, CH_K, CH_I:
                    begin
                        dec_seq[0] = {1'b0, CH_ESC};
                        dec_seq[1] = {1'b0, CH_LBRACKET};
                        dec_seq[2] = {1'b0, (in_char_reg == CH_I) ? CH_M : in_char_reg};
                        dec_len    = SEQ_LEN_W'(3);
                    end
                    CH_Y:
                    begin
                        phase_next = PH_ROW;
                    end
                    CH_Z:
                    begin
                        dec_seq[0] = {1'b0, CH_ESC};
                        dec_seq[1] = {1'b0, CH_SLASH};
                        dec_seq[2] = {1'b0, CH_Z};
                        dec_host   = 1'b1;
                        dec_len    = SEQ_LEN_W'(3);
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            PH_ROW:
            begin
                row_next   = coord_of(in_char_reg);
                phase_next = PH_COL;
            end
            PH_COL:
            begin
                dec_seq[0] = {1'b0, CH_ESC};
                dec_seq[1] = {1'b0, CH_LBRACKET};
                dec_seq[2] = tens_char(row_reg);
                dec_seq[3] = ones_char(row_reg);
                dec_seq[4] = {1'b0, CH_SEMI};
                dec_seq[5] = tens_char(col);
                dec_seq[6] = ones_char(col);
                dec_seq[7] = {1'b0, CH_H};
                dec_len    = SEQ_LEN_W'(MAX_SEQ);
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        len_next = len_reg;
        idx_next = idx_reg;
        if (process)
        begin
            len_next = dec_len;
            idx_next = '0;
        end
        else if (finishing)
        begin
            len_next = '0;
            idx_next = '0;
        end
        else if (taking)
        begin
            idx_next = idx_reg + SEQ_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_IDLE;
            row_reg      <= '0;
            len_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            len_reg      <= len_next;
            idx_reg      <= idx_next;
            if (process)
            begin
                phase_reg <= phase_next;
                row_reg   <= row_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= in_byte[6:0];
        end
        if (process)
        begin
            host_reg <= dec_host;
            for (int i = 0; i < MAX_SEQ; i++)
            begin
                seq_reg[i] <= dec_seq[i];
            end
        end
    end

endmodule

>>> rtl/vt2a_checker.sv
// ----------------------------------------------------------------------------
// VT52 to ANSI translator port checker
// Watches the ports of the core over time; attached to it by bind.
// ----------------------------------------------------------------------------
module vt2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic [7:0] in_byte,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] out_byte,
    input logic       to_host,
    input logic       last,
    input logic       out_valid,
    input logic       out_stall
);

    // A stalled result item stays offered and keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(to_host)
            && $stable(last))
        else $error("result item withdrawn or changed while stalled");

    // A stalled input item stays offered and keeps its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("input item withdrawn or changed while stalled");

    // Once a sequence has started, its remaining bytes follow without a gap.
    a_seq_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside an expansion");

    // The identify reply stays on the host side until its final byte.
    a_reply_whole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && to_host && !last |=> out_valid && to_host)
        else $error("identify reply broken up");

    // Input is held back only while results are pending.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

endmodule

bind vt52_to_ansi_translator_core vt2a_checker u_vt2a_checker (.*);
